/* design/delta_frame_escape_rle_encoder_top_macros.svh */
// ----------------------------------------------------------------------------
// delta_frame_escape_rle_encoder_top_macros
// Assertion helpers shared by the encoder modules.
// ----------------------------------------------------------------------------
`ifndef DELTA_FRAME_ESCAPE_RLE_ENCODER_TOP_MACROS_SVH
`define DELTA_FRAME_ESCAPE_RLE_ENCODER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define DFE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define DFE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/dfe_pkg.sv */
// ----------------------------------------------------------------------------
// dfe_pkg
// Shared types and constants of the delta frame escape rle encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dfe_pkg;

   localparam logic [7:0] MAX_RUN        = 8'd255;
   localparam logic [7:0] RESET_ESCAPE   = 8'd238;
   localparam logic [7:0] RESET_HOLDOVER = 8'd254;

   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] REG_ESCAPE   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HOLDOVER = 8'd1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      SEG_NONE = 2'd0,
      SEG_LIT  = 2'd1,
      SEG_RUN  = 2'd2
   } seg_kind_type;

   // one closed run: either a literal group (1 or 2 pixels) or an escape run
   typedef struct packed {
      seg_kind_type kind;
      logic [1:0]   count;
      logic         esc;
      logic [7:0]   value;
      logic [7:0]   len_m1;
   } seg_type;

   // everything one pixel produces
   typedef struct packed {
      logic    method;
      logic    key;
      seg_type close_seg;
      seg_type flush_seg;
   } cmd_type;

endpackage

`default_nettype wire

/* design/dfe_front.sv */
// ----------------------------------------------------------------------------
// dfe_front
// Accepts pixels, applies the holdover substitution, tracks the pending run
// and hands a burst command to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "delta_frame_escape_rle_encoder_top_macros.svh"

module dfe_front import dfe_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] escape_code,
   input  wire logic [7:0] holdover_index,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire logic [7:0] pixel,
   input  wire logic [7:0] prev_pixel,
   input  wire logic       prev_valid,
   input  wire logic       key_frame,
   input  wire logic       first_of_frame,
   input  wire logic       last_of_line,
   input  wire logic       q_full,
   output logic            push,
   output cmd_type         push_cmd
);

   logic [7:0] run_value_ff, run_value_in;
   logic [7:0] run_length_ff, run_length_in;
   logic       run_open_ff, run_open_in;

   logic       accept;
   logic [7:0] subst;
   logic       open_now;
   logic       extend;
   logic [7:0] new_value;
   logic [7:0] new_length;

   function automatic seg_type make_seg(input logic [7:0] val, input logic [7:0] len,
                                        input logic [7:0] esc_code);
      seg_type s;
      s = '0;
      s.value = val;
      if (len > 8'd2) begin
         s.kind   = SEG_RUN;
         s.len_m1 = len - 8'd1;
      end else begin
         s.kind  = SEG_LIT;
         s.count = len[1:0];
         s.esc   = (val == esc_code);
      end
      return s;
   endfunction

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      if (key_frame) begin
         subst = (pixel == holdover_index) ? 8'd0 : pixel;
      end else if (prev_valid && pixel == prev_pixel) begin
         subst = holdover_index;
      end else begin
         subst = pixel;
      end

      // a frame start drops whatever run the previous line left open
      open_now   = run_open_ff && !first_of_frame;
      extend     = open_now && subst == run_value_ff && run_length_ff != MAX_RUN;
      new_value  = extend ? run_value_ff : subst;
      new_length = extend ? run_length_ff + 8'd1 : 8'd1;

      push_cmd        = '0;
      push_cmd.method = first_of_frame;
      push_cmd.key    = key_frame;
      push_cmd.close_seg.kind = SEG_NONE;
      push_cmd.flush_seg.kind = SEG_NONE;
      if (open_now && !extend) begin
         push_cmd.close_seg = make_seg(run_value_ff, run_length_ff, escape_code);
      end
      if (last_of_line) begin
         push_cmd.flush_seg = make_seg(new_value, new_length, escape_code);
      end

      push = accept && (first_of_frame || push_cmd.close_seg.kind != SEG_NONE
                        || push_cmd.flush_seg.kind != SEG_NONE);

      run_value_in  = run_value_ff;
      run_length_in = run_length_ff;
      run_open_in   = run_open_ff;
      if (accept) begin
         run_value_in  = new_value;
         run_length_in = last_of_line ? 8'd0 : new_length;
         run_open_in   = !last_of_line;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff  <= 8'd0;
         run_length_ff <= 8'd0;
         run_open_ff   <= 1'b0;
      end else begin
         run_value_ff  <= run_value_in;
         run_length_ff <= run_length_in;
         run_open_ff   <= run_open_in;
      end
   end

   `DFE_ASSERT_NXT(a_eol_closes_run, clock, reset, accept && last_of_line, !run_open_ff, "run still open after line end")
   `DFE_ASSERT_NXT(a_run_opened, clock, reset, accept && !last_of_line, run_open_ff && run_length_ff != 8'd0, "pixel did not leave an open run")
   `DFE_ASSERT_IMP(a_frame_start_drops, clock, reset, push && push_cmd.method, push_cmd.close_seg.kind == SEG_NONE, "run closed across frame start")

endmodule

`default_nettype wire

/* design/dfe_queue.sv */
// ----------------------------------------------------------------------------
// dfe_queue
// Small command queue between the pixel front end and the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "delta_frame_escape_rle_encoder_top_macros.svh"

module dfe_queue import dfe_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         not_empty,
   output cmd_type      head_cmd
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QPTR_W'((32'(wr_ptr_ff) + 1) % QUEUE_DEPTH) : wr_ptr_ff;
      rd_ptr_in = pop ? QPTR_W'((32'(rd_ptr_ff) + 1) % QUEUE_DEPTH) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `DFE_ASSERT_IMP(a_no_overflow, clock, reset, push, !full, "push into full queue")
   `DFE_ASSERT_IMP(a_no_underflow, clock, reset, pop, not_empty, "pop from empty queue")

endmodule

`default_nettype wire

/* design/dfe_back.sv */
// ----------------------------------------------------------------------------
// dfe_back
// Expands queued burst commands into the byte stream, one byte per cycle while
// out_ready is high, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "delta_frame_escape_rle_encoder_top_macros.svh"

module dfe_back import dfe_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] escape_code,
   input  wire logic       q_valid,
   input  wire cmd_type    q_cmd,
   output logic            q_pop,
   output logic            out_valid,
   input  wire logic       out_ready,
   output logic [7:0]      out_byte,
   output logic            out_last
);

   cmd_type    cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [2:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;

   logic       load;
   logic       advance;
   logic       done;
   logic [2:0] method_n;
   logic [2:0] close_n;
   logic [2:0] flush_n;
   logic [2:0] total;
   logic [2:0] rel;
   logic [7:0] sel_byte;

   function automatic logic [2:0] seg_bytes(input seg_type s);
      logic [2:0] n;
      unique case (s.kind)
         SEG_RUN: n = 3'd3;
         SEG_LIT: n = s.esc ? {s.count, 1'b0} : {1'b0, s.count};
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] seg_byte(input seg_type s, input logic [2:0] k,
                                           input logic [7:0] esc_code);
      logic [7:0] b;
      unique case (s.kind)
         SEG_RUN: begin
            if (k == 3'd0) begin
               b = esc_code;
            end else if (k == 3'd1) begin
               b = s.len_m1;
            end else begin
               b = s.value;
            end
         end
         // escaped literal goes out as escape, 0
         SEG_LIT: b = (s.esc && k[0]) ? 8'd0 : s.value;
         default: b = s.value;
      endcase
      return b;
   endfunction

   always_comb begin
      method_n = {2'b00, cur_ff.method};
      close_n  = seg_bytes(cur_ff.close_seg);
      flush_n  = seg_bytes(cur_ff.flush_seg);
      total    = method_n + close_n + flush_n;
      rel      = idx_ff - method_n;

      priority if (idx_ff < method_n) begin
         sel_byte = {7'd0, cur_ff.key};
      end else if (rel < close_n) begin
         sel_byte = seg_byte(cur_ff.close_seg, rel, escape_code);
      end else begin
         sel_byte = seg_byte(cur_ff.flush_seg, rel - close_n, escape_code);
      end

      load    = !out_valid_ff || out_ready;
      advance = load && cur_valid_ff;
      done    = advance && (idx_ff == total - 3'd1);
      q_pop   = q_valid && (!cur_valid_ff || done);

      cur_in       = q_pop ? q_cmd : cur_ff;
      cur_valid_in = q_pop ? 1'b1 : (done ? 1'b0 : cur_valid_ff);
      idx_in       = (done || q_pop) ? 3'd0 : (advance ? idx_ff + 3'd1 : idx_ff);

      out_valid_in = load ? cur_valid_ff : out_valid_ff;
      out_byte_in  = advance ? sel_byte : out_byte_ff;
      out_last_in  = advance ? done : out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign out_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign out_last  = out_last_ff;

   `DFE_ASSERT_IMP(a_idx_in_burst, clock, reset, cur_valid_ff, idx_ff < total, "byte index past end of burst")

endmodule

`default_nettype wire

/* design/delta_frame_escape_rle_encoder_top.sv */
// ----------------------------------------------------------------------------
// delta_frame_escape_rle_encoder_top
// Escape-code run-length encoder for indexed pixels with key/delta frames.
//
//   channel | prefix | direction | transfer
//   pixels  | req_   | in        | one pixel with previous-frame pixel and marks
//   bytes   | rsp_   | out       | one output byte, last_of_burst on the final one
//   config  | csr_   | in        | register write, no wait, no read-back
//
// The front end takes one pixel per cycle while the 4-entry command queue has
// room. The serializer sends one byte per cycle while rsp_ready is high.
// A burst's first byte passes through a queue entry, the serializer's command
// register and the output register before it appears on rsp_out_byte.
// Reset is synchronous; it clears the open run, the queue and the output stage.
// A stalled rsp_ready fills the queue and then drops req_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_frame_escape_rle_encoder_top import dfe_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [7:0]             req_pixel,
   input  wire logic [7:0]             req_prev_pixel,
   input  wire logic                   req_prev_valid,
   input  wire logic                   req_key_frame,
   input  wire logic                   req_first_of_frame,
   input  wire logic                   req_last_of_line,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_last_of_burst,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]             csr_wdata
);

   logic [7:0] escape_ff, escape_in;
   logic [7:0] holdover_ff, holdover_in;

   logic    q_push;
   cmd_type q_push_cmd;
   logic    q_full;
   logic    q_pop;
   logic    q_not_empty;
   cmd_type q_head;

   always_comb begin
      escape_in   = escape_ff;
      holdover_in = holdover_ff;
      if (csr_write_en) begin
         if (csr_index == REG_ESCAPE) begin
            escape_in = csr_wdata;
         end else if (csr_index == REG_HOLDOVER) begin
            holdover_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff   <= RESET_ESCAPE;
         holdover_ff <= RESET_HOLDOVER;
      end else begin
         escape_ff   <= escape_in;
         holdover_ff <= holdover_in;
      end
   end

   dfe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .escape_code    (escape_ff),
      .holdover_index (holdover_ff),
      .in_valid       (req_valid),
      .in_ready       (req_ready),
      .pixel          (req_pixel),
      .prev_pixel     (req_prev_pixel),
      .prev_valid     (req_prev_valid),
      .key_frame      (req_key_frame),
      .first_of_frame (req_first_of_frame),
      .last_of_line   (req_last_of_line),
      .q_full         (q_full),
      .push           (q_push),
      .push_cmd       (q_push_cmd)
   );

   dfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (q_head)
   );

   dfe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .escape_code (escape_ff),
      .q_valid     (q_not_empty),
      .q_cmd       (q_head),
      .q_pop       (q_pop),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_byte    (rsp_out_byte),
      .out_last    (rsp_last_of_burst)
   );

endmodule

`default_nettype wire

/* dv/delta_frame_escape_rle_encoder_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delta_frame_escape_rle_encoder_top_tb
// Self-checking bench for the escape-code run-length pixel encoder. A table of
// hand-picked pixels comes first: frame marks, key and delta substitution,
// escape literals, runs and line flushes. Random frames of lines follow under
// several escape/holdover settings, with one line long enough to hit the run
// cap. Every output byte is checked against the table's bytes or an in-bench
// encoder model; both channels idle in random bursts save in the final phase.
// ----------------------------------------------------------------------------

module delta_frame_escape_rle_encoder_top_tb;
   import dfe_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 16;
   localparam int ERRORS_SHOWN  = 10;

   // indexes that decode to no register
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_LO = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_HI = 8'd255;

   typedef struct packed {
      logic [7:0] pixel;
      logic [7:0] prev_pixel;
      logic       prev_valid;
      logic       key_frame;
      logic       first_of_frame;
      logic       last_of_line;
   } pixel_item_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_byte_type;

   // typed rows carry their bytes left-aligned, first byte in the top octet
   typedef struct packed {
      pixel_item_type item;
      logic           typed;
      logic [2:0]     n_bytes;
      logic [47:0]    bytes;
   } stim_row_type;

   // reset settings: escape EE, holdover FE
   localparam stim_row_type DIR_ROWS [22] = '{
      //  pixel  prev   pv    key   first eol     typed n     bytes
      '{'{8'd5,   8'd0,   1'b0, 1'b1, 1'b1, 1'b1}, 1'b1, 3'd2, 48'h0105_0000_0000},
      '{'{8'd254, 8'd0,   1'b0, 1'b1, 1'b0, 1'b1}, 1'b1, 3'd1, 48'h0000_0000_0000},
      '{'{8'd238, 8'd0,   1'b0, 1'b1, 1'b0, 1'b1}, 1'b1, 3'd2, 48'hEE00_0000_0000},
      '{'{8'd7,   8'd0,   1'b0, 1'b1, 1'b0, 1'b0}, 1'b1, 3'd0, 48'h0000_0000_0000},
      '{'{8'd7,   8'd0,   1'b0, 1'b1, 1'b0, 1'b0}, 1'b1, 3'd0, 48'h0000_0000_0000},
      '{'{8'd7,   8'd0,   1'b0, 1'b1, 1'b0, 1'b1}, 1'b1, 3'd3, 48'hEE02_0700_0000},
      '{'{8'd255, 8'd255, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b1, 3'd1, 48'h0000_0000_0000},
      '{'{8'd255, 8'd255, 1'b1, 1'b0, 1'b0, 1'b1}, 1'b1, 3'd2, 48'hFEFE_0000_0000},
      '{'{8'd3,   8'd3,   1'b0, 1'b0, 1'b0, 1'b1}, 1'b1, 3'd1, 48'h0300_0000_0000},
      '{'{8'd4,   8'd4,   1'b1, 1'b1, 1'b1, 1'b1}, 1'b1, 3'd2, 48'h0104_0000_0000},
      '{'{8'd10,  8'd0,   1'b0, 1'b1, 1'b0, 1'b0}, 1'b1, 3'd0, 48'h0000_0000_0000},
      '{'{8'd11,  8'd0,   1'b0, 1'b1, 1'b1, 1'b1}, 1'b1, 3'd2, 48'h010B_0000_0000},
      '{'{8'd238, 8'd0,   1'b0, 1'b1, 1'b0, 1'b0}, 1'b1, 3'd0, 48'h0000_0000_0000},
      '{'{8'd238, 8'd0,   1'b0, 1'b1, 1'b0, 1'b0}, 1'b1, 3'd0, 48'h0000_0000_0000},
      '{'{8'd0,   8'd0,   1'b0, 1'b1, 1'b0, 1'b1}, 1'b1, 3'd5, 48'hEE00_EE00_0000},
      '{'{8'd0,   8'd0,   1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, 3'd0, 48'h0000_0000_0000},
      '{'{8'd0,   8'd1,   1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, 3'd0, 48'h0000_0000_0000},
      '{'{8'd128, 8'd127, 1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, 3'd0, 48'h0000_0000_0000},
      '{'{8'd254, 8'd0,   1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, 3'd0, 48'h0000_0000_0000},
      '{'{8'd127, 8'd128, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, 3'd0, 48'h0000_0000_0000},
      '{'{8'd127, 8'd127, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, 3'd0, 48'h0000_0000_0000},
      '{'{8'd254, 8'd3,   1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, 3'd0, 48'h0000_0000_0000}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [7:0]             req_pixel;
   logic [7:0]             req_prev_pixel;
   logic                   req_prev_valid;
   logic                   req_key_frame;
   logic                   req_first_of_frame;
   logic                   req_last_of_line;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [7:0]             rsp_out_byte;
   logic                   rsp_last_of_burst;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [7:0]             csr_wdata;

   // encoder model state and settings
   logic [7:0] esc_code = RESET_ESCAPE;
   logic [7:0] hold_idx = RESET_HOLDOVER;
   logic [7:0] run_val  = 8'd0;
   logic [7:0] run_len  = 8'd0;
   logic       run_open = 1'b0;

   logic [7:0]   burst_q [$];
   out_byte_type expected_bytes [$];
   out_byte_type head;

   int  errors        = 0;
   int  pixels_sent   = 0;
   int  bytes_checked = 0;
   int  csr_writes    = 0;
   int  cycles        = 0;
   int  gap_pct       = 20;
   bit  calm          = 1'b0;

   delta_frame_escape_rle_encoder_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pixel          (req_pixel),
      .req_prev_pixel     (req_prev_pixel),
      .req_prev_valid     (req_prev_valid),
      .req_key_frame      (req_key_frame),
      .req_first_of_frame (req_first_of_frame),
      .req_last_of_line   (req_last_of_line),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_of_burst  (rsp_last_of_burst),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void flag_error(input string msg);
      errors++;
      if (errors <= ERRORS_SHOWN) $display("%0t mismatch: %s", $time, msg);
   endfunction

   // emits the pending run into burst_q
   function automatic void close_run();
      if (!run_open) return;
      if (run_len > 8'd2) begin
         burst_q.push_back(esc_code);
         burst_q.push_back(run_len - 8'd1);
         burst_q.push_back(run_val);
      end else begin
         for (int i = 0; i < run_len; i++) begin
            if (run_val == esc_code) begin
               burst_q.push_back(esc_code);
               burst_q.push_back(8'd0);
            end else begin
               burst_q.push_back(run_val);
            end
         end
      end
      run_open = 1'b0;
      run_len  = 8'd0;
   endfunction

   // bytes one pixel causes, in order: method byte, closed run, line flush
   function automatic void encode_pixel(input pixel_item_type it);
      logic [7:0] v;
      burst_q.delete();
      v = it.pixel;
      if (it.first_of_frame) begin
         // an unterminated run is dropped at a frame start
         run_open = 1'b0;
         run_len  = 8'd0;
         burst_q.push_back({7'd0, it.key_frame});
      end
      if (it.key_frame) begin
         if (it.pixel == hold_idx) v = 8'd0;
      end else if (it.prev_valid && it.pixel == it.prev_pixel) begin
         v = hold_idx;
      end
      if (run_open && v == run_val && run_len < MAX_RUN) begin
         run_len++;
      end else begin
         close_run();
         run_val  = v;
         run_len  = 8'd1;
         run_open = 1'b1;
      end
      if (it.last_of_line) close_run();
   endfunction

   task automatic send_pixel(input pixel_item_type it, input logic typed,
                             input logic [2:0] n_typed, input logic [47:0] typed_bytes);
      @(negedge clock);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_pixel          <= it.pixel;
      req_prev_pixel     <= it.prev_pixel;
      req_prev_valid     <= it.prev_valid;
      req_key_frame      <= it.key_frame;
      req_first_of_frame <= it.first_of_frame;
      req_last_of_line   <= it.last_of_line;
      do @(posedge clock); while (!req_ready);
      encode_pixel(it);
      if (typed) begin
         burst_q.delete();
         for (int k = 0; k < n_typed; k++) burst_q.push_back(typed_bytes[47 - 8 * k -: 8]);
      end
      foreach (burst_q[k])
         expected_bytes.push_back('{data: burst_q[k], last: (k == burst_q.size() - 1)});
      pixels_sent++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      if (idx == REG_ESCAPE) esc_code = data;
      else if (idx == REG_HOLDOVER) hold_idx = data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      csr_writes++;
   endtask

   // stop sending, let every byte out, then give the pipe time to empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // frames of 1 to 3 lines; a few lines get broken marks or mixed flags
   task automatic send_frames(input int n_items);
      int             sent;
      int             lines;
      int             len;
      logic           key;
      logic           pv;
      bit             noisy;
      logic [7:0]     last_px;
      pixel_item_type it;
      sent    = 0;
      last_px = 8'd0;
      while (sent < n_items) begin
         key   = ($urandom_range(0, 2) == 0);
         pv    = ($urandom_range(0, 5) != 0);
         lines = $urandom_range(1, 3);
         for (int l = 0; l < lines && sent < n_items; l++) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 10);
            case ($urandom_range(0, 2))
               0:       gap_pct = 0;
               1:       gap_pct = 15;
               default: gap_pct = 50;
            endcase
            noisy = ($urandom_range(0, 9) == 0);
            for (int p = 0; p < len && sent < n_items; p++) begin
               case ($urandom_range(0, 9))
                  0:       it.pixel = esc_code;
                  1:       it.pixel = hold_idx;
                  2:       it.pixel = 8'd0;
                  3:       it.pixel = 8'd255;
                  4, 5:    it.pixel = 8'($urandom_range(0, 255));
                  default: it.pixel = last_px;
               endcase
               it.prev_pixel     = $urandom_range(0, 1) ? it.pixel : 8'($urandom_range(0, 255));
               it.prev_valid     = noisy ? 1'($urandom_range(0, 1)) : pv;
               it.key_frame      = (noisy && $urandom_range(0, 3) == 0) ? !key : key;
               it.first_of_frame = (l == 0 && p == 0) || (noisy && $urandom_range(0, 9) == 0);
               it.last_of_line   = (p == len - 1) && !(noisy && $urandom_range(0, 2) == 0);
               send_pixel(it, 1'b0, 3'd0, 48'd0);
               last_px = it.pixel;
               sent++;
            end
         end
      end
   endtask

   // receiver stalls in bursts; the stall rate is redrawn from 0, 8 or 30 percent
   initial begin
      int stall_left;
      int stall_pct;
      int span;
      rsp_ready  = 1'b0;
      stall_left = 0;
      stall_pct  = 10;
      span       = 0;
      forever begin
         @(negedge clock);
         span++;
         if (span == 64) begin
            span = 0;
            case ($urandom_range(0, 2))
               0:       stall_pct = 0;
               1:       stall_pct = 8;
               default: stall_pct = 30;
            endcase
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            flag_error($sformatf("unexpected byte %02h last_of_burst %0b",
                                 rsp_out_byte, rsp_last_of_burst));
         end else begin
            head = expected_bytes.pop_front();
            if (rsp_out_byte !== head.data)
               flag_error($sformatf("byte %0d out_byte expected %02h got %02h",
                                    bytes_checked, head.data, rsp_out_byte));
            if (rsp_last_of_burst !== head.last)
               flag_error($sformatf("byte %0d last_of_burst expected %0b got %0b",
                                    bytes_checked, head.last, rsp_last_of_burst));
         end
         bytes_checked++;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes still due", cycles, expected_bytes.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [7:0] shared;
      logic [7:0] run_px;
      logic       run_key;
      int         run_n;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_pixel          = 8'd0;
      req_prev_pixel     = 8'd0;
      req_prev_valid     = 1'b0;
      req_key_frame      = 1'b0;
      req_first_of_frame = 1'b0;
      req_last_of_line   = 1'b0;
      csr_write_en       = 1'b0;
      csr_index          = REG_ESCAPE;
      csr_wdata          = 8'd0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIR_ROWS[r])
         send_pixel(DIR_ROWS[r].item, DIR_ROWS[r].typed, DIR_ROWS[r].n_bytes, DIR_ROWS[r].bytes);
      settle();

      // extremes, plus writes that must not land anywhere
      write_csr(REG_ESCAPE, 8'd0);
      write_csr(REG_HOLDOVER, 8'd255);
      write_csr(REG_UNUSED_LO, 8'($urandom_range(0, 255)));
      send_frames(40);
      settle();

      write_csr(REG_ESCAPE, 8'd255);
      write_csr(REG_HOLDOVER, 8'd0);
      write_csr(REG_UNUSED_HI, 8'($urandom_range(0, 255)));
      send_frames(40);
      settle();

      // escape and holdover collide
      shared = 8'($urandom_range(0, 255));
      write_csr(REG_ESCAPE, shared);
      write_csr(REG_HOLDOVER, shared);
      send_frames(40);
      settle();

      // one line that runs past the cap
      write_csr(REG_ESCAPE, 8'($urandom_range(0, 255)));
      write_csr(REG_HOLDOVER, 8'($urandom_range(0, 255)));
      run_px  = 8'($urandom_range(0, 255));
      run_key = 1'($urandom_range(0, 1));
      run_n   = 255 + $urandom_range(1, 3);
      gap_pct = 10;
      for (int p = 0; p < run_n; p++)
         send_pixel('{run_px, run_px, 1'b1, run_key, p == 0, p == run_n - 1}, 1'b0, 3'd0, 48'd0);
      settle();

      // back at reset settings, both sides at full rate
      calm = 1'b1;
      write_csr(REG_ESCAPE, RESET_ESCAPE);
      write_csr(REG_HOLDOVER, RESET_HOLDOVER);
      send_frames(30);
      settle();

      $display("sent %0d pixels (%0d table rows), checked %0d bytes, %0d register writes",
               pixels_sent, $size(DIR_ROWS), bytes_checked, csr_writes);
      $display("settings: reset, escape/holdover extremes both ways, a collision, a capped run");
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", errors);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/dfe_pkg.sv
design/dfe_front.sv
design/dfe_queue.sv
design/dfe_back.sv
design/delta_frame_escape_rle_encoder_top.sv
dv/delta_frame_escape_rle_encoder_top_tb.sv
